>>> hw/rtl/lti_pkg.sv
package lti_pkg;

    localparam int DATA_W     = 32;
    localparam int ROWS_DEF   = 16;
    localparam int IDX_W      = 4;
    localparam int CFG_W      = 5;
    localparam int DIVIDEND_W = 2 * DATA_W;
    localparam int QUO_W      = 34;
    localparam int DIV_CNT_W  = $clog2(QUO_W + 1);

    localparam logic MODE_WRITE = 1'b0;
    localparam logic MODE_EVAL  = 1'b1;

    localparam logic signed [DATA_W-1:0] Q_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] Q_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic             done;
        logic             ovf;
        logic [QUO_W-1:0] quo;
    } t_div_stat;

endpackage

>>> hw/rtl/lti_ram.sv
module lti_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/lti_div.sv
module lti_div
    import lti_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [DIVIDEND_W-1:0] i_dividend,
    input  logic [DATA_W-1:0]     i_divisor,
    output t_div_stat             o_stat
);

    logic                 r_busy;
    logic                 r_done;
    logic                 r_ovf;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DATA_W-1:0]    r_rem;
    logic [DATA_W-1:0]    r_div;
    logic [QUO_W-1:0]     r_quo;

    logic [DIVIDEND_W-QUO_W-1:0] hi;
    logic [DATA_W:0]             trial;
    logic                        ge;

    // Quotient bits above QUO_W only tell that the result overflows
    assign hi    = i_dividend[DIVIDEND_W-1:QUO_W];
    assign trial = {r_rem, r_quo[QUO_W-1]};
    assign ge    = trial >= {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_div <= i_divisor;
                r_quo <= i_dividend[QUO_W-1:0];
                r_rem <= DATA_W'(hi);
                r_cnt <= DIV_CNT_W'(QUO_W);
                if (DATA_W'(hi) >= i_divisor) begin
                    r_ovf  <= 1'b1;
                    r_done <= 1'b1;
                end else begin
                    r_ovf  <= 1'b0;
                    r_busy <= 1'b1;
                end
            end else if (r_busy) begin
                r_rem <= ge ? DATA_W'(trial - {1'b0, r_div}) : trial[DATA_W-1:0];
                r_quo <= {r_quo[QUO_W-2:0], ge};
                r_cnt <= r_cnt - DIV_CNT_W'(1);
                if (r_cnt == DIV_CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.ovf  = r_ovf;
    assign o_stat.quo  = r_quo;

endmodule

>>> hw/rtl/lookup_table_interpolator.sv
// Piecewise-linear lookup of a sensor response curve, signed Q16.16.
// Input stream: tuser is the mode. A write transaction (mode 0) stores one
// table row at row_index. An evaluate transaction (mode 1) scans the rows in
// use for the first pair bracketing the sample, extrapolates from the first or
// last segment when none does, and returns one result transaction (result in
// tdata, saturated flag in tuser). With no rows in use the result is the
// sample itself; with one row it is that row's output point. Rows in use are
// set through i_cfg_we / i_cfg_wdata while the block is idle; the user must
// keep to this, the block itself does not enforce it. The row scan reads the
// table memory (separate read and write ports) one row a cycle, and the serial
// divider yields its 34 quotient bits one a cycle; a degenerate segment skips
// the divider, and a quotient that is known to overflow ends the divide at
// once. The block takes no new transaction while an evaluation runs and is
// ready for the next one once the result is loaded into the output register.
// The result sits in an output register, so a stalled receiver does not block
// further writes or the next evaluation until that evaluation has a result of
// its own to hand over.
// Reset clears the row count to zero and empties the output register; table
// contents are undefined until written.
module lookup_table_interpolator
    import lti_pkg::*;
#(
    parameter int ROWS = ROWS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // row_index[3:0], row_point_in[35:4], row_point_out[67:36], sample[99:68]
    input  logic [103:0]      s_axis_tdata,
    // mode[0]
    input  logic              s_axis_tuser,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // result[31:0]
    output logic [DATA_W-1:0] m_axis_tdata,
    // saturated[0]
    output logic              m_axis_tuser
);

    localparam int AW    = $clog2(ROWS);
    localparam int CNT_W = $clog2(ROWS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_SEG,
        S_MUL,
        S_DSTART,
        S_DIV,
        S_OUT
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0]         r_rows;
    logic [CNT_W-1:0]         r_n;
    logic signed [DATA_W-1:0] r_v;
    logic [AW-1:0]            r_addr;
    logic [AW-1:0]            r_idx;
    logic                     r_got;
    logic signed [DATA_W-1:0] r_px, r_py, r_ax, r_ay, r_bx, r_by;
    logic signed [DATA_W-1:0] r_sx, r_sy, r_ex, r_ey;
    logic                     r_asc;
    logic signed [DATA_W:0]   r_dy;
    logic [DATA_W-1:0]        r_mdy, r_mdv, r_mdx;
    logic                     r_neg, r_dx_zero, r_dv_neg, r_dv_zero;
    logic [DIVIDEND_W-1:0]    r_prod;
    logic signed [DATA_W-1:0] r_res;
    logic                     r_sat;
    logic                     r_out_vld;
    logic [DATA_W-1:0]        r_out_data;
    logic                     r_out_sat;

    // input fields
    logic [IDX_W-1:0]         f_idx;
    logic signed [DATA_W-1:0] f_pin, f_pout, f_sample;
    logic                     in_acc;

    assign f_idx    = s_axis_tdata[3:0];
    assign f_pin    = s_axis_tdata[35:4];
    assign f_pout   = s_axis_tdata[67:36];
    assign f_sample = s_axis_tdata[99:68];

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;

    // table memory: {output point, input point}
    logic                    ram_we;
    logic [2*DATA_W-1:0]     ram_rdata;
    logic signed [DATA_W-1:0] cur_x, cur_y;

    assign ram_we = in_acc && (s_axis_tuser == MODE_WRITE) && (32'(f_idx) < ROWS);
    assign cur_x  = ram_rdata[DATA_W-1:0];
    assign cur_y  = ram_rdata[2*DATA_W-1:DATA_W];

    lti_ram #(
        .WIDTH(2 * DATA_W),
        .DEPTH(ROWS)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(AW'(f_idx)),
        .i_wdata({f_pout, f_pin}),
        .i_raddr(r_addr),
        .o_rdata(ram_rdata)
    );

    // divider
    t_div_stat div_stat;

    lti_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (r_state == S_DSTART),
        .i_dividend(r_prod),
        .i_divisor (r_mdx),
        .o_stat    (div_stat)
    );

    // rows in use, limited to the table depth
    logic [CNT_W-1:0] n_rows;
    assign n_rows = (32'(r_rows) > ROWS) ? CNT_W'(ROWS) : CNT_W'(r_rows);

    // scan
    logic bracket, last_row, asc_c, use_last, idx_one;
    logic signed [DATA_W-1:0] row1_x, row1_y;

    assign bracket  = (r_v < r_px && r_v >= cur_x) || (r_v >= r_px && r_v < cur_x);
    assign last_row = (CNT_W'(r_idx) == r_n - CNT_W'(1));
    assign asc_c    = r_ax < cur_x;
    assign use_last = (asc_c && r_v >= r_ax) || (!asc_c && r_v < r_ax);
    assign idx_one  = (r_idx == AW'(1));
    assign row1_x   = idx_one ? cur_x : r_bx;
    assign row1_y   = idx_one ? cur_y : r_by;

    // segment differences
    logic signed [DATA_W:0] dx, dy, dv;
    logic [DATA_W:0]        ndx, ndy, ndv;

    assign dx  = 33'(r_ex) - 33'(r_sx);
    assign dy  = 33'(r_ey) - 33'(r_sy);
    assign dv  = 33'(r_v) - 33'(r_sx);
    assign ndx = -dx;
    assign ndy = -dy;
    assign ndv = -dv;

    // degenerate segment
    logic                   dv_pos, take_start, take_end;
    logic signed [DATA_W+1:0] mid;

    assign dv_pos     = !r_dv_neg && !r_dv_zero;
    assign take_start = r_asc ? r_dv_neg : dv_pos;
    assign take_end   = r_asc ? dv_pos : r_dv_neg;
    // truncate dy / 2 toward zero: add one back for odd negative values
    assign mid = 34'(r_sy) + 34'(r_dy >>> 1) + $signed({33'b0, r_dy[DATA_W] & r_dy[0]});

    // final add and clamp
    logic                     q_sat;
    logic signed [DATA_W+3:0] q_ext, sum;

    assign q_sat = div_stat.ovf || (div_stat.quo[QUO_W-1] && (|div_stat.quo[QUO_W-2:0]));
    assign q_ext = $signed({2'b00, div_stat.quo});
    assign sum   = r_neg ? 36'(r_sy) - q_ext : 36'(r_sy) + q_ext;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_rows    <= '0;
            r_out_vld <= 1'b0;
            r_got     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_rows <= i_cfg_wdata;
            end
            if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (in_acc && s_axis_tuser == MODE_EVAL) begin
                        r_v    <= f_sample;
                        r_n    <= n_rows;
                        r_addr <= '0;
                        r_got  <= 1'b0;
                        if (n_rows == '0) begin
                            r_res   <= f_sample;
                            r_sat   <= 1'b0;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end

                S_SCAN: begin
                    r_addr <= r_addr + AW'(1);
                    r_idx  <= r_addr;
                    r_got  <= 1'b1;
                    if (r_got) begin
                        r_px <= cur_x;
                        r_py <= cur_y;
                        if (r_idx == '0) begin
                            r_ax <= cur_x;
                            r_ay <= cur_y;
                            if (r_n == CNT_W'(1)) begin
                                r_res   <= cur_y;
                                r_sat   <= 1'b0;
                                r_state <= S_OUT;
                            end
                        end else begin
                            if (idx_one) begin
                                r_bx <= cur_x;
                                r_by <= cur_y;
                            end
                            if (bracket) begin
                                r_sx    <= r_px;
                                r_sy    <= r_py;
                                r_ex    <= cur_x;
                                r_ey    <= cur_y;
                                r_asc   <= 1'b0;
                                r_state <= S_SEG;
                            end else if (last_row) begin
                                r_asc <= asc_c;
                                if (use_last) begin
                                    r_sx <= r_px;
                                    r_sy <= r_py;
                                    r_ex <= cur_x;
                                    r_ey <= cur_y;
                                end else begin
                                    r_sx <= r_ax;
                                    r_sy <= r_ay;
                                    r_ex <= row1_x;
                                    r_ey <= row1_y;
                                end
                                r_state <= S_SEG;
                            end
                        end
                    end
                end

                S_SEG: begin
                    r_dy      <= dy;
                    r_mdx     <= dx[DATA_W] ? ndx[DATA_W-1:0] : dx[DATA_W-1:0];
                    r_mdy     <= dy[DATA_W] ? ndy[DATA_W-1:0] : dy[DATA_W-1:0];
                    r_mdv     <= dv[DATA_W] ? ndv[DATA_W-1:0] : dv[DATA_W-1:0];
                    r_neg     <= (dy[DATA_W] ^ dv[DATA_W]) ^ dx[DATA_W];
                    r_dx_zero <= (dx == '0);
                    r_dv_neg  <= dv[DATA_W];
                    r_dv_zero <= (dv == '0);
                    r_state   <= S_MUL;
                end

                S_MUL: begin
                    r_prod <= DIVIDEND_W'(r_mdy) * DIVIDEND_W'(r_mdv);
                    if (r_dx_zero) begin
                        r_sat <= 1'b0;
                        if (take_start) begin
                            r_res <= r_sy;
                        end else if (take_end) begin
                            r_res <= r_ey;
                        end else begin
                            r_res <= mid[DATA_W-1:0];
                        end
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_DSTART;
                    end
                end

                S_DSTART: begin
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    if (div_stat.done) begin
                        if (q_sat) begin
                            r_sat <= 1'b1;
                            r_res <= r_neg ? Q_MIN : Q_MAX;
                        end else if (sum > 36'(Q_MAX)) begin
                            r_sat <= 1'b1;
                            r_res <= Q_MAX;
                        end else if (sum < 36'(Q_MIN)) begin
                            r_sat <= 1'b1;
                            r_res <= Q_MIN;
                        end else begin
                            r_sat <= 1'b0;
                            r_res <= sum[DATA_W-1:0];
                        end
                        r_state <= S_OUT;
                    end
                end

                S_OUT: begin
                    // hand over once the output register is free
                    if (!r_out_vld || m_axis_tready) begin
                        r_out_vld  <= 1'b1;
                        r_out_data <= r_res;
                        r_out_sat  <= r_sat;
                        r_state    <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_sat;

endmodule

>>> verif/lti_result_checker.sv
module lti_result_checker
    import lti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_W-1:0]  i_cfg_wdata,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [103:0]      i_s_tdata,
    input  logic              i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [DATA_W-1:0] i_m_tdata,
    input  logic              i_m_tuser,
    output int                o_err_count,
    output int                o_pending
);

    typedef struct packed {
        logic signed [63:0] val;
        logic               sat;
    } t_seg_val;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              sat;
    } t_lookup_result;

    logic signed [DATA_W-1:0] tab_x [ROWS_DEF];
    logic signed [DATA_W-1:0] tab_y [ROWS_DEF];
    logic [CFG_W-1:0]         rows_cfg;
    t_lookup_result           lookup_q [$];

    initial begin
        o_err_count = 0;
        o_pending   = 0;
        rows_cfg    = '0;
    end

    function automatic t_seg_val segment_value(longint v, longint sx, longint sy,
                                               longint ex, longint ey, bit asc);
        longint            dx, dy, dv, r;
        longint unsigned   mdx, mdy, mdv, q;
        bit                neg;
        t_seg_val          s;
        dx    = ex - sx;
        dy    = ey - sy;
        dv    = v - sx;
        s.sat = 1'b0;
        if (dx == 0) begin
            // degenerate segment: pick an end by side, midpoint when on the point
            if ((asc && v < sx) || (!asc && v > sx))
                s.val = sy;
            else if ((asc && v > sx) || (!asc && v < sx))
                s.val = ey;
            else
                s.val = sy + dy / 2;
            return s;
        end
        mdx = (dx < 0) ? longint'(-dx) : longint'(dx);
        mdy = (dy < 0) ? longint'(-dy) : longint'(dy);
        mdv = (dv < 0) ? longint'(-dv) : longint'(dv);
        q   = (mdy * mdv) / mdx;
        neg = ((dy < 0) != (dv < 0)) != (dx < 0);
        if (q == 0) begin
            s.val = sy;
        end else if (q > (64'd1 << 33)) begin
            s.sat = 1'b1;
            s.val = neg ? longint'(Q_MIN) : longint'(Q_MAX);
        end else begin
            r = neg ? sy - longint'(q) : sy + longint'(q);
            if (r > longint'(Q_MAX)) begin
                s.sat = 1'b1;
                s.val = longint'(Q_MAX);
            end else if (r < longint'(Q_MIN)) begin
                s.sat = 1'b1;
                s.val = longint'(Q_MIN);
            end else begin
                s.val = r;
            end
        end
        return s;
    endfunction

    function automatic t_lookup_result interp_predict(logic signed [DATA_W-1:0] samp);
        longint         v, a, b, first;
        int             n, i, last;
        bit             found, asc;
        t_seg_val       s;
        t_lookup_result p;
        v     = samp;
        n     = (rows_cfg > ROWS_DEF) ? ROWS_DEF : rows_cfg;
        p.sat = 1'b0;
        if (n == 0) begin
            p.res = samp;
        end else if (n == 1) begin
            p.res = tab_y[0];
        end else begin
            found = 1'b0;
            s     = '0;
            for (i = 0; i + 1 < n; i++) begin
                if (!found) begin
                    a = tab_x[i];
                    b = tab_x[i+1];
                    if ((v < a && v >= b) || (v >= a && v < b)) begin
                        s     = segment_value(v, a, tab_y[i], b, tab_y[i+1], 1'b0);
                        found = 1'b1;
                    end
                end
            end
            if (!found) begin
                // no bracket: extrapolate from the end the table runs toward
                first = tab_x[0];
                last  = n - 1;
                asc   = first < longint'(tab_x[last]);
                if ((asc && v >= first) || (!asc && v < first))
                    s = segment_value(v, tab_x[last-1], tab_y[last-1], tab_x[last],
                                      tab_y[last], asc);
                else
                    s = segment_value(v, tab_x[0], tab_y[0], tab_x[1], tab_y[1], asc);
            end
            p.res = s.val[DATA_W-1:0];
            p.sat = s.sat;
        end
        return p;
    endfunction

    task automatic report_mismatch(input string what, input logic [DATA_W-1:0] got,
                                   input logic [DATA_W-1:0] want);
        $display("%0t: %s mismatch: got %h, expected %h", $time, what, got, want);
        o_err_count++;
    endtask

    always @(posedge i_clk) begin
        t_lookup_result e;
        if (!i_rst_n) begin
            rows_cfg = '0;
            lookup_q.delete();
        end else begin
            if (i_cfg_we)
                rows_cfg = i_cfg_wdata;
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser == MODE_WRITE) begin
                    tab_x[i_s_tdata[3:0]] = i_s_tdata[35:4];
                    tab_y[i_s_tdata[3:0]] = i_s_tdata[67:36];
                end else begin
                    lookup_q.push_back(interp_predict(i_s_tdata[99:68]));
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (lookup_q.size() == 0) begin
                    report_mismatch("result without pending evaluation", i_m_tdata, '0);
                end else begin
                    e = lookup_q.pop_front();
                    if (i_m_tdata !== e.res)
                        report_mismatch("result", i_m_tdata, e.res);
                    if (i_m_tuser !== e.sat)
                        report_mismatch("saturated", 32'(i_m_tuser), 32'(e.sat));
                end
            end
        end
        o_pending <= lookup_q.size();
    end

endmodule

>>> verif/tb_lookup_table_interpolator.sv
module tb_lookup_table_interpolator
    import lti_pkg::*;
;

    localparam int          ITEM_TARGET     = 575;
    localparam int          EVALS_PER_PHASE = 30;
    localparam int          DRAIN_CYCLES    = 64;
    localparam int unsigned LIMIT_CYCLES    = 500000;

    typedef enum int {
        TBL_ASC,
        TBL_DESC,
        TBL_RANDOM,
        TBL_DUPS,
        TBL_FLAT,
        TBL_STEEP
    } t_tbl_kind;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]  i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [103:0]      s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic              m_axis_tuser;

    int                err_count;
    int                pending;
    int                items_sent   = 0;
    int unsigned       cycle_count  = 0;
    bit                src_quiet    = 1'b0;
    bit                sink_quiet   = 1'b0;

    // local copy of the table points, used only to aim samples
    logic signed [DATA_W-1:0] tx [ROWS_DEF];
    logic signed [DATA_W-1:0] ty [ROWS_DEF];

    lookup_table_interpolator u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    lti_result_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (s_axis_tvalid),
        .i_s_tready  (s_axis_tready),
        .i_s_tdata   (s_axis_tdata),
        .i_s_tuser   (s_axis_tuser),
        .i_m_tvalid  (m_axis_tvalid),
        .i_m_tready  (m_axis_tready),
        .i_m_tdata   (m_axis_tdata),
        .i_m_tuser   (m_axis_tuser),
        .o_err_count (err_count),
        .o_pending   (pending)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver: after each transaction hold tready low for a drawn number of
    // cycles counted from when the next result shows up
    initial begin
        int stall;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            stall = sink_quiet ? 0 : $urandom_range(0, 13);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                do @(posedge i_clk); while (!m_axis_tvalid);
                repeat (stall - 1) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    task automatic send_item(input logic mode, input logic [IDX_W-1:0] idx,
                             input logic [31:0] pin, input logic [31:0] pout,
                             input logic [31:0] samp);
        int gap;
        gap = src_quiet ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {4'b0, samp, pout, pin, idx};
        do @(posedge i_clk); while (!s_axis_tready);
        items_sent++;
    endtask

    task automatic write_row(input logic [IDX_W-1:0] idx, input logic [31:0] pin,
                             input logic [31:0] pout);
        tx[idx] = pin;
        ty[idx] = pout;
        send_item(MODE_WRITE, idx, pin, pout, $urandom);
    endtask

    task automatic eval_sample(input logic [31:0] samp);
        send_item(MODE_EVAL, IDX_W'($urandom), $urandom, $urandom, samp);
    endtask

    // change the row count only once every result is out and the block is quiet
    task automatic set_rows(input logic [CFG_W-1:0] n);
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= n;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    task automatic build_table(input t_tbl_kind kind);
        longint x;
        int     i, off, dir;
        x   = longint'($urandom_range(0, 1 << 24)) - (1 << 23);
        dir = $urandom_range(0, 1) ? 1 : -1;
        off = $urandom_range(0, 15);
        for (i = 0; i < ROWS_DEF; i++) begin
            case (kind)
                TBL_ASC: begin
                    tx[i] = 32'(x);
                    ty[i] = $signed($urandom) >>> 6;
                    x += longint'($urandom_range(1, 1 << 20));
                end
                TBL_DESC: begin
                    tx[i] = 32'(x);
                    ty[i] = $signed($urandom) >>> 6;
                    x -= longint'($urandom_range(1, 1 << 20));
                end
                TBL_RANDOM: begin
                    tx[i] = $urandom;
                    ty[i] = $urandom;
                end
                TBL_DUPS: begin
                    tx[i] = 32'(x);
                    ty[i] = $signed($urandom) >>> 8;
                    if ($urandom_range(0, 1))
                        x += dir * longint'($urandom_range(1, 1 << 16));
                end
                TBL_FLAT: begin
                    tx[i] = 32'(x);
                    ty[i] = $urandom;
                end
                default: begin
                    tx[i] = 32'(x);
                    ty[i] = $urandom;
                    x += longint'($urandom_range(1, 16));
                end
            endcase
        end
        // write the rows in a rotated order so the write sequence varies
        for (i = 0; i < ROWS_DEF; i++)
            write_row(IDX_W'((off + i) % ROWS_DEF), tx[(off + i) % ROWS_DEF],
                      ty[(off + i) % ROWS_DEF]);
    endtask

    function automatic logic [31:0] pick_sample();
        int     k;
        longint base, span;
        k = $urandom_range(0, ROWS_DEF - 2);
        case ($urandom_range(0, 9))
            0:       return $urandom;
            1:       return $urandom_range(0, 1) ? Q_MAX : Q_MIN;
            2, 3:    return tx[k];
            4:       return tx[k] + ($urandom_range(0, 1) ? 32'sd1 : -32'sd1);
            5, 6, 7: begin
                base = tx[k];
                span = longint'(tx[k+1]) - base;
                return 32'(base + span * longint'($urandom_range(0, 255)) / 256);
            end
            default: begin
                base = $urandom_range(0, 1) ? tx[0] : tx[ROWS_DEF-1];
                return 32'(base + longint'($urandom_range(0, 1 << 21)) - (1 << 20));
            end
        endcase
    endfunction

    initial begin
        int           i;
        logic [CFG_W-1:0] n;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through with no rows in use
        eval_sample(Q_MIN);
        eval_sample(Q_MAX);
        eval_sample(32'h0);

        // small ascending table with a falling last segment
        write_row(4'd0, 32'sh0,     32'sh0);
        write_row(4'd1, 32'sh10000, 32'sh000a0000);
        write_row(4'd2, 32'sh20000, 32'sh001e0000);
        write_row(4'd3, 32'sh30000, 32'sh00140000);
        set_rows(5'd1);
        eval_sample(32'sh50000);
        set_rows(5'd4);
        eval_sample(32'sh8000);
        eval_sample(32'sh20000);
        eval_sample(32'sh28000);
        eval_sample(-32'sh10000);
        eval_sample(32'sh70000);
        eval_sample(Q_MIN);

        // make the last segment degenerate (equal input points): midpoint on the point, end output beyond
        write_row(4'd3, 32'sh20000, 32'sh00320000);
        eval_sample(32'sh20000);
        eval_sample(32'sh50000);

        // descending table with extreme outputs
        write_row(4'd0, 32'sh30000, 32'sh0);
        write_row(4'd1, 32'sh20000, Q_MAX);
        write_row(4'd2, 32'sh10000, Q_MIN);
        write_row(4'd3, 32'sh0,     32'sh5);
        eval_sample(Q_MAX);
        eval_sample(32'sh18000);
        eval_sample(-32'sh50000);

        while (items_sent < ITEM_TARGET) begin
            src_quiet  = ($urandom_range(0, 3) == 0);
            sink_quiet = ($urandom_range(0, 3) == 0);
            build_table(t_tbl_kind'($urandom_range(0, 5)));
            case ($urandom_range(0, 7))
                0:       n = 5'd0;
                1:       n = 5'd1;
                2:       n = 5'd2;
                3:       n = 5'd16;
                default: n = CFG_W'($urandom_range(2, 16));
            endcase
            set_rows(n);
            for (i = 0; i < EVALS_PER_PHASE; i++) begin
                if ($urandom_range(0, 99) < 15)
                    write_row(IDX_W'($urandom), pick_sample(), $urandom);
                else
                    eval_sample(pick_sample());
            end
        end

        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
